/* rtl/core/btf_pkg.sv */
// package for the back-to-front draw sorter
// item types, sizes and status codes; no dependencies

package btf_pkg;

	// storage sizes
	localparam int MAX_ENTRIES    = 64;
	localparam int INDEX_CAPACITY = 1048576;

	// field widths fixed by the item formats
	localparam int CMD_W    = 2;
	localparam int DEPTH_W  = 32;
	localparam int GROUP_W  = 8;
	localparam int COUNT_W  = 21;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;
	localparam int START_W  = 20;

	// derived widths
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W = $clog2(INDEX_CAPACITY + 1);
	localparam int SUM_W = ((TOT_W > COUNT_W) ? TOT_W : COUNT_W) + 1;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_ZBUFFER_ENABLE = 1'b0;

	// commands
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REJ_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJ_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd6;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [DEPTH_W-1:0] depth;
		logic [GROUP_W-1:0]        group;
		logic [COUNT_W-1:0]        word_count;
	} sub_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [SLOT_W-1:0]         slot;
		logic signed [DEPTH_W-1:0] out_depth;
		logic [GROUP_W-1:0]        out_group;
		logic [START_W-1:0]        word_offset;
		logic [COUNT_W-1:0]        out_count;
		logic                      last;
	} res_item_t;

endpackage

/* rtl/core/back_to_front_draw_sorter.sv */
// top level of the back-to-front draw sorter: submission list, sort sequencer
// and configuration register; depends on btf_pkg
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  sub      | sub_valid, sub_stall, sub (sub_item_t)   | in
//  res      | res_valid, res_stall, res (res_item_t)   | out
//  cfg      | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// add, clear, an unused command and the single-result emits can follow back to
// back while the result is not stalled. an emit of n entries runs n passes over
// the entry memory through one depth compare unit: each pass reads every entry
// and then loads the result register. reset clears the sequencer state, counters
// and flags and sets the z-buffer enable; the entry memory is not cleared.
// a stalled result holds the result register and the sequencer waits for it.

module back_to_front_draw_sorter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sub_valid,
	output logic                            sub_stall,
	input  btf_pkg::sub_item_t              sub,
	output logic                            res_valid,
	input  logic                            res_stall,
	output btf_pkg::res_item_t              res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [btf_pkg::ADDR_W-1:0]      paddr,
	input  logic [btf_pkg::DATA_W-1:0]      pwdata,
	output logic [btf_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import btf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	// entry memories
	logic signed [DEPTH_W-1:0] depth_mem [MAX_ENTRIES];
	logic [GROUP_W-1:0]        group_mem [MAX_ENTRIES];
	logic [START_W-1:0]        start_mem [MAX_ENTRIES];
	logic [COUNT_W-1:0]        count_mem [MAX_ENTRIES];

	logic [1:0]       state_q;
	logic             zen_q;
	logic [CNT_W-1:0] entry_total_q;
	logic [TOT_W-1:0] index_total_q;
	logic             res_valid_q;
	res_item_t        res_q;

	// scan registers
	logic [CNT_W-1:0]          scan_cnt_q;
	logic [CNT_W-1:0]          emit_cnt_q;
	logic                      rd_v_s1;
	logic [IDX_W-1:0]          rd_idx_s1;
	logic signed [DEPTH_W-1:0] rd_depth_s1;
	logic [GROUP_W-1:0]        rd_group_s1;
	logic [START_W-1:0]        rd_start_s1;
	logic [COUNT_W-1:0]        rd_count_s1;
	logic                      first_q;
	logic                      have_best_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic signed [DEPTH_W-1:0] best_depth_q;
	logic [GROUP_W-1:0]        best_group_q;
	logic [START_W-1:0]        best_start_q;
	logic [COUNT_W-1:0]        best_count_q;
	logic [IDX_W-1:0]          last_idx_q;
	logic signed [DEPTH_W-1:0] last_depth_q;

	logic             res_free;
	logic             accept;
	logic [SUM_W-1:0] new_total;
	logic             add_ok;
	logic             issue;
	logic             pass_done;
	logic             eligible;
	logic             better;
	logic             emit_last;
	logic             cfg_write;

	// handshakes
	assign res_free  = !res_valid_q || !res_stall;
	assign sub_stall = !((state_q == S_IDLE) && res_free);
	assign accept    = sub_valid && !sub_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// add checks
	assign new_total = SUM_W'(index_total_q) + SUM_W'(sub.word_count);
	assign add_ok    = accept && (sub.cmd == CMD_ADD) && (sub.word_count != '0) &&
		(entry_total_q < CNT_W'(MAX_ENTRIES)) && (new_total <= SUM_W'(INDEX_CAPACITY));

	// scan issue and end of pass
	assign issue     = (state_q == S_SCAN) && (scan_cnt_q != entry_total_q);
	assign pass_done = (state_q == S_SCAN) && (scan_cnt_q == entry_total_q) && !rd_v_s1;

	// shared compare: after the last emitted entry, and ahead of the best so far
	assign eligible = first_q || (rd_depth_s1 < last_depth_q) ||
		((rd_depth_s1 == last_depth_q) && (rd_idx_s1 > last_idx_q));
	assign better   = !have_best_q || (rd_depth_s1 > best_depth_q);
	assign emit_last = ((emit_cnt_q + CNT_W'(1)) == entry_total_q);

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_ZBUFFER_ENABLE) ? DATA_W'(zen_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zen_q <= 1'b1;
		end else if (cfg_write && (paddr[2] == REG_ZBUFFER_ENABLE)) begin
			zen_q <= pwdata[0];
		end
	end

	// entry memory write and registered read
	always_ff @(posedge clk) begin
		if (add_ok) begin
			depth_mem[entry_total_q[IDX_W-1:0]] <= sub.depth;
			group_mem[entry_total_q[IDX_W-1:0]] <= sub.group;
			start_mem[entry_total_q[IDX_W-1:0]] <= START_W'(index_total_q);
			count_mem[entry_total_q[IDX_W-1:0]] <= sub.word_count;
		end
		if (issue) begin
			rd_idx_s1   <= scan_cnt_q[IDX_W-1:0];
			rd_depth_s1 <= depth_mem[scan_cnt_q[IDX_W-1:0]];
			rd_group_s1 <= group_mem[scan_cnt_q[IDX_W-1:0]];
			rd_start_s1 <= start_mem[scan_cnt_q[IDX_W-1:0]];
			rd_count_s1 <= count_mem[scan_cnt_q[IDX_W-1:0]];
		end
	end

	// best candidate of the current pass
	always_ff @(posedge clk) begin
		if (rd_v_s1 && eligible && better) begin
			best_idx_q   <= rd_idx_s1;
			best_depth_q <= rd_depth_s1;
			best_group_q <= rd_group_s1;
			best_start_q <= rd_start_s1;
			best_count_q <= rd_count_s1;
		end
		if ((state_q == S_EMIT) && res_free) begin
			last_idx_q   <= best_idx_q;
			last_depth_q <= best_depth_q;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= '0;
			res_q.last <= 1'b1;
			unique case (sub.cmd)
				CMD_ADD: begin
					if (sub.word_count == '0) begin
						res_q.status <= ST_REJ_EMPTY;
					end else if (!add_ok) begin
						res_q.status <= ST_REJ_FULL;
					end else begin
						res_q.status      <= ST_ACCEPTED;
						res_q.slot        <= SLOT_W'(entry_total_q[IDX_W-1:0]);
						res_q.out_depth   <= sub.depth;
						res_q.out_group   <= sub.group;
						res_q.word_offset <= START_W'(index_total_q);
						res_q.out_count   <= sub.word_count;
					end
				end
				CMD_EMIT: begin
					if (!zen_q) begin
						res_q.status <= ST_DISABLED;
					end else begin
						res_q.status <= ST_NONE;
					end
				end
				CMD_CLEAR: begin
					res_q.status <= ST_CLEARED;
				end
				default: begin
					res_q.status <= ST_NONE;
				end
			endcase
		end else if ((state_q == S_EMIT) && res_free) begin
			res_q.status      <= ST_ENTRY;
			res_q.slot        <= SLOT_W'(best_idx_q);
			res_q.out_depth   <= best_depth_q;
			res_q.out_group   <= best_group_q;
			res_q.word_offset <= best_start_q;
			res_q.out_count   <= best_count_q;
			res_q.last        <= emit_last;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_total_q <= '0;
			index_total_q <= '0;
			res_valid_q   <= 1'b0;
			scan_cnt_q    <= '0;
			emit_cnt_q    <= '0;
			rd_v_s1       <= 1'b0;
			first_q       <= 1'b0;
			have_best_q   <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			rd_v_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (sub.cmd)
							CMD_ADD: begin
								res_valid_q <= 1'b1;
								if (add_ok) begin
									entry_total_q <= entry_total_q + CNT_W'(1);
									index_total_q <= TOT_W'(new_total);
								end
							end
							CMD_EMIT: begin
								if (zen_q && (entry_total_q != '0)) begin
									state_q     <= S_SCAN;
									scan_cnt_q  <= '0;
									emit_cnt_q  <= '0;
									first_q     <= 1'b1;
									have_best_q <= 1'b0;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								res_valid_q   <= 1'b1;
								entry_total_q <= '0;
								index_total_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (rd_v_s1 && eligible && better) begin
						have_best_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						emit_cnt_q  <= emit_cnt_q + CNT_W'(1);
						first_q     <= 1'b0;
						have_best_q <= 1'b0;
						scan_cnt_q  <= '0;
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
